// ===== rtl/core/pdet_pkg.sv =====
// Shared types and constants for the per-day earliest-time table.
// No dependencies; compiled first.
`default_nettype none

package pdet_pkg;

    localparam int LOC_PORT_W  = 10;
    localparam int TIME_W      = 16;
    localparam int DAYS_PORT_W = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_WALK,
        ST_MERGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DAYS_PORT_W-1:0] improved_days;
        logic                   table_full;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/pdet_upd_if.sv =====
// Update channel: location, candidate time and day mask with valid/ready.
// Depends on pdet_pkg.
`default_nettype none

interface pdet_upd_if import pdet_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LOC_PORT_W-1:0]  location;
    logic [TIME_W-1:0]      arrival_time;
    logic [DAYS_PORT_W-1:0] day_mask;

    modport source (output valid, location, arrival_time, day_mask, input ready);
    modport sink   (input valid, location, arrival_time, day_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pdet_res_if.sv =====
// Result channel: improvement mask and full flag with valid/ready.
// Depends on pdet_pkg.
`default_nettype none

interface pdet_res_if import pdet_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [DAYS_PORT_W-1:0] improved_days;
    logic                   table_full;

    modport source (output valid, improved_days, table_full, input ready);
    modport sink   (input valid, improved_days, table_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/per_day_earliest_time_table_top.sv =====
// Top level of the per-day earliest-time table.
// Depends on pdet_pkg, pdet_upd_if, pdet_res_if, pdet_walk, pdet_outreg.
//
//   channel  | dir | beat payload                              | handshake
//   i_upd    | in  | location, arrival_time, day_mask          | valid/ready
//   o_res    | out | improved_days, table_full                 | valid/ready
//
// An update fetches the entry count, walks the n live entries (at most
// MAX_ENTRIES) through the read-modify-write of the entry memory, merges,
// and hands its result to the output register; an out-of-range location or
// a drained mask skips to the hand-off. Updates are processed one at a time.
// After reset the count memory is cleared, one location per cycle, through
// all NUM_LOCATIONS locations; i_upd.ready stays low during that pass.
// A stalled o_res holds its beat; the sequencer takes the next update as soon
// as the output register has room for its result.
`default_nettype none

module per_day_earliest_time_table_top import pdet_pkg::*; #(
    parameter int NUM_LOCATIONS = 1024,
    parameter int MAX_ENTRIES   = 8,
    parameter int NUM_DAYS      = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdet_upd_if.sink  i_upd,
    pdet_res_if.source o_res
);

    // sequencer to output register
    logic    res_valid;
    logic    res_ready;
    t_result res_data;

    // walk engine: count and entry memories, per-entry update
    pdet_walk #(
        .NUM_LOCATIONS (NUM_LOCATIONS),
        .MAX_ENTRIES   (MAX_ENTRIES),
        .NUM_DAYS      (NUM_DAYS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (i_upd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_data)
    );

    // result beat buffer, decouples the walk from downstream stalls
    pdet_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res_data),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pdet_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pdet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdet_walk.sv =====
// Update sequencer: count memory, entry memory and the per-entry walk.
// Depends on pdet_pkg, pdet_upd_if, pdet_ram.
`default_nettype none

module pdet_walk import pdet_pkg::*; #(
    parameter int NUM_LOCATIONS = 1024,
    parameter int MAX_ENTRIES   = 8,
    parameter int NUM_DAYS      = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pdet_upd_if.sink    i_upd,
    output logic        o_res_valid,
    input  wire logic   i_res_ready,
    output t_result     o_res
);

    localparam int LOC_W   = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_NUM = NUM_LOCATIONS * MAX_ENTRIES;
    localparam int AW      = (ENT_NUM > 1) ? $clog2(ENT_NUM) : 1;
    localparam int EW      = TIME_W + NUM_DAYS;

    t_state               r_state, n_state;
    logic [LOC_W-1:0]     r_clr, n_clr;
    logic [LOC_W-1:0]     r_loc, n_loc;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [NUM_DAYS-1:0]  r_work, n_work;
    logic [AW-1:0]        r_base, n_base;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_i, n_i;
    logic                 r_have_same, n_have_same;
    logic                 r_have_free, n_have_free;
    logic [AW-1:0]        r_same_at, n_same_at;
    logic [AW-1:0]        r_free_at, n_free_at;
    logic [NUM_DAYS-1:0]  r_same_days, n_same_days;
    t_result              r_res, n_res;

    // memory ports
    logic                 cnt_we;
    logic [LOC_W-1:0]     cnt_waddr, cnt_raddr;
    logic [CW-1:0]        cnt_wdata, cnt_rdata;
    logic                 ent_we;
    logic [AW-1:0]        ent_waddr, ent_raddr;
    logic [EW-1:0]        ent_wdata, ent_rdata;

    // input decode
    logic [31:0]          w_loc32;
    logic [LOC_W-1:0]     w_loc_idx;
    logic                 w_in_range;
    logic [CW-1:0]        w_cnt_n;

    // entry step
    logic [TIME_W-1:0]    w_et;
    logic [NUM_DAYS-1:0]  w_ed, w_nd, w_nwork;
    logic                 w_later, w_same, w_empty;
    logic [CW-1:0]        w_inext;
    logic [AW-1:0]        w_addr;

    assign w_loc32    = 32'(i_upd.location);
    assign w_loc_idx  = w_loc32[LOC_W-1:0];
    assign w_in_range = (w_loc32 < 32'(NUM_LOCATIONS));
    assign w_cnt_n    = (cnt_rdata > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cnt_rdata;

    assign w_et    = ent_rdata[NUM_DAYS +: TIME_W];
    assign w_ed    = ent_rdata[NUM_DAYS-1:0];
    assign w_later = (r_time < w_et);
    assign w_nd    = w_later ? (w_ed & ~r_work) : w_ed;
    assign w_nwork = w_later ? r_work : (r_work & ~w_ed);
    assign w_same  = !w_later && (r_time == w_et);
    assign w_empty = (w_nd == '0);
    assign w_inext = r_i + CW'(1);
    assign w_addr  = r_base + AW'(r_i);

    pdet_ram #(.WIDTH(CW), .DEPTH(NUM_LOCATIONS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    pdet_ram #(.WIDTH(EW), .DEPTH(ENT_NUM)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_loc       <= n_loc;
        r_time      <= n_time;
        r_work      <= n_work;
        r_base      <= n_base;
        r_n         <= n_n;
        r_i         <= n_i;
        r_have_same <= n_have_same;
        r_have_free <= n_have_free;
        r_same_at   <= n_same_at;
        r_free_at   <= n_free_at;
        r_same_days <= n_same_days;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_loc       = r_loc;
        n_time      = r_time;
        n_work      = r_work;
        n_base      = r_base;
        n_n         = r_n;
        n_i         = r_i;
        n_have_same = r_have_same;
        n_have_free = r_have_free;
        n_same_at   = r_same_at;
        n_free_at   = r_free_at;
        n_same_days = r_same_days;
        n_res       = r_res;

        i_upd.ready = 1'b0;
        o_res_valid = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = r_loc;
        cnt_wdata   = '0;
        cnt_raddr   = w_loc_idx;
        ent_we      = 1'b0;
        ent_waddr   = w_addr;
        ent_wdata   = {w_et, w_nd};
        ent_raddr   = r_base;

        unique case (r_state)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                n_clr     = r_clr + LOC_W'(1);
                if (r_clr == LOC_W'(NUM_LOCATIONS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_upd.ready = 1'b1;
                if (i_upd.valid) begin
                    n_loc       = w_loc_idx;
                    n_time      = i_upd.arrival_time;
                    n_work      = i_upd.day_mask[NUM_DAYS-1:0];
                    n_base      = AW'(int'(w_loc_idx) * MAX_ENTRIES);
                    n_have_same = 1'b0;
                    n_have_free = 1'b0;
                    if (w_in_range) begin
                        n_state = ST_COUNT;
                    end else begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_COUNT: begin
                n_n = w_cnt_n;
                n_i = '0;
                n_state = (w_cnt_n == '0) ? ST_MERGE : ST_WALK;
            end
            ST_WALK: begin
                if (r_work == '0) begin
                    // working mask drained: walk stops, nothing more is stored
                    n_res   = '0;
                    n_state = ST_DONE;
                end else begin
                    ent_we = w_later;
                    n_work = w_nwork;
                    if (w_same) begin
                        n_have_same = 1'b1;
                        n_same_at   = w_addr;
                        n_same_days = w_ed;
                    end
                    if (w_empty) begin
                        n_have_free = 1'b1;
                        n_free_at   = w_addr;
                    end
                    if (w_inext < r_n) begin
                        n_i       = w_inext;
                        ent_raddr = r_base + AW'(w_inext);
                    end else begin
                        n_state = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                n_res.improved_days = DAYS_PORT_W'(r_work);
                n_res.table_full    = 1'b0;
                n_state             = ST_DONE;
                priority if (r_work == '0) begin
                    n_res = '0;
                end else if (r_have_same) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_same_at;
                    ent_wdata = {r_time, r_same_days | r_work};
                end else if (r_have_free) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_free_at;
                    ent_wdata = {r_time, r_work};
                end else if (r_n < CW'(MAX_ENTRIES)) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_base + AW'(r_n);
                    ent_wdata = {r_time, r_work};
                    cnt_we    = 1'b1;
                    cnt_wdata = r_n + CW'(1);
                end else begin
                    n_res.table_full = 1'b1;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/pdet_outreg.sv =====
// Output register between the sequencer and the result channel.
// Depends on pdet_pkg, pdet_res_if.
`default_nettype none

module pdet_outreg import pdet_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_result  i_res,
    pdet_res_if.source    o_res
);

    logic    r_valid;
    t_result r_data;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.improved_days = r_data.improved_days;
    assign o_res.table_full    = r_data.table_full;

endmodule

`default_nettype wire

// ===== rtl/core/pdet_chk.sv =====
// Port-level checker for the per-day earliest-time table, bound to the top.
// Depends on per_day_earliest_time_table_top ports only.
`default_nettype none

module pdet_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_upd_valid,
    input wire logic        i_upd_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [63:0] i_improved_days,
    input wire logic        i_table_full
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_improved_days) && $stable(i_table_full))
        else $error("result beat changed while stalled");

    // a full flag only comes with days that were dropped
    a_full_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_table_full |-> i_improved_days != 64'd0)
        else $error("table_full without improved days");

    // one update at a time: no back-to-back accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd_valid && i_upd_ready |=> !i_upd_ready)
        else $error("update accepted while previous one in progress");

    // coming out of reset: clearing pass, nothing offered
    a_post_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_upd_ready && !i_res_valid)
        else $error("block active right after reset");

endmodule

bind per_day_earliest_time_table_top pdet_chk u_pdet_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_upd_valid     (i_upd.valid),
    .i_upd_ready     (i_upd.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_improved_days (o_res.improved_days),
    .i_table_full    (o_res.table_full)
);

`default_nettype wire
